>>> rtl/owm_pkg.sv
// types, codes and reset constants shared by the 1-wire bus master
// no dependencies

package owm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam int LONG_W        = 10;
    localparam int SHORT_W       = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 10;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_REC  = 4'd3,
        PH_SLOT     = 4'd4,
        PH_WR_HOLD  = 4'd5,
        PH_WR_REC   = 4'd6,
        PH_RD_WAIT  = 4'd7,
        PH_RD_TAIL  = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        CMD_RESET = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESET_LOW   = 3'd0,
        REG_PRES_SAMPLE = 3'd1,
        REG_RESET_REC   = 3'd2,
        REG_SLOT_START  = 3'd3,
        REG_WR_HOLD     = 3'd4,
        REG_WR_REC      = 3'd5,
        REG_RD_SAMPLE   = 3'd6,
        REG_RD_TAIL     = 3'd7
    } cfg_idx_t;

    localparam logic [LONG_W-1:0]  RST_RESET_LOW   = 10'd500;
    localparam logic [LONG_W-1:0]  RST_PRES_SAMPLE = 10'd90;
    localparam logic [LONG_W-1:0]  RST_RESET_REC   = 10'd460;
    localparam logic [SHORT_W-1:0] RST_SLOT_START  = 8'd2;
    localparam logic [SHORT_W-1:0] RST_WR_HOLD     = 8'd76;
    localparam logic [SHORT_W-1:0] RST_WR_REC      = 8'd2;
    localparam logic [SHORT_W-1:0] RST_RD_SAMPLE   = 8'd2;
    localparam logic [SHORT_W-1:0] RST_RD_TAIL     = 8'd76;

    typedef struct packed {
        logic [LONG_W-1:0]  reset_low_time;
        logic [LONG_W-1:0]  presence_sample_time;
        logic [LONG_W-1:0]  reset_recovery_time;
        logic [SHORT_W-1:0] slot_start_time;
        logic [SHORT_W-1:0] write_hold_time;
        logic [SHORT_W-1:0] write_recovery_time;
        logic [SHORT_W-1:0] read_sample_delay;
        logic [SHORT_W-1:0] read_tail_time;
    } cfg_t;

    typedef struct packed {
        logic                     start_req;
        logic [1:0]               operation;
        logic [BITS_PER_BYTE-1:0] write_byte;
        logic                     bus_level;
    } tick_in_t;

    typedef struct packed {
        logic [BITS_PER_BYTE-1:0] read_byte;
        logic                     presence;
        logic                     done_res;
        logic                     busy_res;
        logic                     pull_low;
    } tick_out_t;

endpackage

>>> rtl/onewire_bus_master.sv
// top level of the 1-wire bus master: streams, timing registers, sequencer
// depends on owm_pkg, owm_cfg, owm_core, owm_outreg
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/tready        tdata: write_byte, bus_level
//                                                   tuser: start_req, operation
//  m_axis    out        m_axis_tvalid/tready        tdata: pull_low, busy, done,
//                                                   presence, read_byte
//  cfg       in         cfg_valid/cfg_ready         cfg_index, cfg_data
//
// every item is one microsecond tick; the sequencer finishes it in the cycle it
// is accepted and the result lands in the output register, so one item per cycle
// is sustained as long as the result side takes its items
// rst_n clears the phase state, the read/presence results and the timing
// registers to their default values
// when the output register is full and not taken, s_axis_tready drops and the
// tick stream stalls; config writes are always taken

module onewire_bus_master
    import owm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // [7:0] write_byte, [8] bus_level, rest 0
    input  logic [2:0]            s_axis_tuser,  // [0] start_req, [2:1] operation

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,  // [0] pull_low, [1] busy_res,
                                                 // [2] done_res, [3] presence,
                                                 // [11:4] read_byte, rest 0

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg;
    tick_in_t  tick_in;
    tick_out_t tick_out;
    tick_out_t res;
    logic      in_accept;
    logic      can_load;

    // config writes need no back-pressure
    assign cfg_ready = 1'b1;

    // unpack the incoming tick item
    assign tick_in.start_req  = s_axis_tuser[0];
    assign tick_in.operation  = s_axis_tuser[2:1];
    assign tick_in.write_byte = s_axis_tdata[7:0];
    assign tick_in.bus_level  = s_axis_tdata[8];

    assign s_axis_tready = can_load;
    assign in_accept     = s_axis_tvalid && can_load;

    owm_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // phase state advances only on an accepted tick
    owm_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick_en  (in_accept),
        .tick_in  (tick_in),
        .cfg      (cfg),
        .tick_out (tick_out)
    );

    owm_outreg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_accept),
        .load_data (tick_out),
        .take      (m_axis_tready),
        .can_load  (can_load),
        .valid     (m_axis_tvalid),
        .data      (res)
    );

    // pack the result item, low bits first
    assign m_axis_tdata = {4'b0000, res.read_byte, res.presence, res.done_res,
                           res.busy_res, res.pull_low};

    // an accepted tick always shows up as a result next cycle
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> m_axis_tvalid)
        else $error("accepted tick produced no result");

    // a finishing tick never reports busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(res.done_res && res.busy_res))
        else $error("done and busy both set");

    // the line is only driven during a command
    a_pull_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.pull_low) |-> res.busy_res)
        else $error("bus pulled low while not busy");

endmodule

>>> rtl/owm_cfg.sv
// timing register file of the 1-wire bus master
// depends on owm_pkg

module owm_cfg
    import owm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                REG_RESET_LOW:   cfg_next.reset_low_time       = wr_data[LONG_W-1:0];
                REG_PRES_SAMPLE: cfg_next.presence_sample_time = wr_data[LONG_W-1:0];
                REG_RESET_REC:   cfg_next.reset_recovery_time  = wr_data[LONG_W-1:0];
                REG_SLOT_START:  cfg_next.slot_start_time      = wr_data[SHORT_W-1:0];
                REG_WR_HOLD:     cfg_next.write_hold_time      = wr_data[SHORT_W-1:0];
                REG_WR_REC:      cfg_next.write_recovery_time  = wr_data[SHORT_W-1:0];
                REG_RD_SAMPLE:   cfg_next.read_sample_delay    = wr_data[SHORT_W-1:0];
                REG_RD_TAIL:     cfg_next.read_tail_time       = wr_data[SHORT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time       <= RST_RESET_LOW;
            cfg_reg.presence_sample_time <= RST_PRES_SAMPLE;
            cfg_reg.reset_recovery_time  <= RST_RESET_REC;
            cfg_reg.slot_start_time      <= RST_SLOT_START;
            cfg_reg.write_hold_time      <= RST_WR_HOLD;
            cfg_reg.write_recovery_time  <= RST_WR_REC;
            cfg_reg.read_sample_delay    <= RST_RD_SAMPLE;
            cfg_reg.read_tail_time       <= RST_RD_TAIL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/owm_core.sv
// phase sequencer of the 1-wire bus master: one tick per accepted item
// depends on owm_pkg

module owm_core
    import owm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      tick_en,
    input  tick_in_t  tick_in,
    input  cfg_t      cfg,
    output tick_out_t tick_out
);

    phase_t                   phase_reg, phase_next;
    logic [LONG_W-1:0]        tick_count_reg, tick_count_next;
    logic [BIT_IDX_W-1:0]     bit_index_reg, bit_index_next;
    logic [BITS_PER_BYTE-1:0] shift_byte_reg, shift_byte_next;
    cmd_t                     command_reg, command_next;
    logic                     presence_reg, presence_next;
    logic [BITS_PER_BYTE-1:0] read_result_reg, read_result_next;

    phase_t                   ph;
    logic [LONG_W-1:0]        count_inc;
    logic [LONG_W-1:0]        phase_len;
    logic [LONG_W-1:0]        raw_len;
    logic                     bit_value;
    logic                     start_ok;
    logic                     pull;
    logic                     done;

    assign start_ok = (phase_reg == PH_IDLE) && tick_in.start_req
                      && (cmd_t'(tick_in.operation) != CMD_NONE);

    always_comb
    begin
        case (ph)
            PH_RST_LOW:  raw_len = cfg.reset_low_time;
            PH_RST_WAIT: raw_len = cfg.presence_sample_time;
            PH_RST_REC:  raw_len = cfg.reset_recovery_time;
            PH_SLOT:     raw_len = LONG_W'(cfg.slot_start_time);
            PH_WR_HOLD:  raw_len = LONG_W'(cfg.write_hold_time);
            PH_WR_REC:   raw_len = LONG_W'(cfg.write_recovery_time);
            PH_RD_WAIT:  raw_len = LONG_W'(cfg.read_sample_delay);
            default:     raw_len = LONG_W'(cfg.read_tail_time);
        endcase
        // a zero duration behaves as a single tick
        phase_len = (raw_len == '0) ? LONG_W'(1) : raw_len;
    end

    always_comb
    begin
        ph               = phase_reg;
        tick_count_next  = tick_count_reg;
        bit_index_next   = bit_index_reg;
        shift_byte_next  = shift_byte_reg;
        command_next     = command_reg;
        presence_next    = presence_reg;
        read_result_next = read_result_reg;
        pull             = 1'b0;
        done             = 1'b0;

        if (start_ok)
        begin
            command_next    = cmd_t'(tick_in.operation);
            tick_count_next = '0;
            bit_index_next  = '0;
            shift_byte_next = (cmd_t'(tick_in.operation) == CMD_WRITE) ?
                              tick_in.write_byte : '0;
            ph              = (cmd_t'(tick_in.operation) == CMD_RESET) ?
                              PH_RST_LOW : PH_SLOT;
        end

        phase_next = ph;
        bit_value  = shift_byte_next[bit_index_next];
        count_inc  = tick_count_next + LONG_W'(1);

        if (ph != PH_IDLE)
        begin
            if (ph == PH_RST_LOW || ph == PH_SLOT)
                pull = 1'b1;
            else if (ph == PH_WR_HOLD)
                pull = !bit_value;

            tick_count_next = count_inc;
            if (count_inc >= phase_len)
            begin
                tick_count_next = '0;
                case (ph)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        presence_next = !tick_in.bus_level;
                        phase_next    = PH_RST_REC;
                    end
                    PH_RST_REC:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_SLOT:
                        phase_next = (command_next == CMD_WRITE) ? PH_WR_HOLD : PH_RD_WAIT;
                    PH_WR_HOLD:  phase_next = PH_WR_REC;
                    PH_RD_WAIT:
                    begin
                        shift_byte_next[bit_index_next] = shift_byte_next[bit_index_next]
                                                          | tick_in.bus_level;
                        phase_next = PH_RD_TAIL;
                    end
                    default:
                    begin
                        // write recovery or read tail closes the slot
                        if (bit_index_next == BIT_IDX_W'(BITS_PER_BYTE - 1))
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                            if (ph == PH_RD_TAIL)
                                read_result_next = shift_byte_next;
                        end
                        else
                        begin
                            bit_index_next = bit_index_next + BIT_IDX_W'(1);
                            phase_next     = PH_SLOT;
                        end
                    end
                endcase
            end
        end

        tick_out.pull_low  = pull;
        tick_out.busy_res  = (phase_next != PH_IDLE);
        tick_out.done_res  = done;
        tick_out.presence  = presence_next;
        tick_out.read_byte = read_result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            tick_count_reg  <= '0;
            bit_index_reg   <= '0;
            shift_byte_reg  <= '0;
            command_reg     <= CMD_RESET;
            presence_reg    <= 1'b0;
            read_result_reg <= '0;
        end
        else if (tick_en)
        begin
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            bit_index_reg   <= bit_index_next;
            shift_byte_reg  <= shift_byte_next;
            command_reg     <= command_next;
            presence_reg    <= presence_next;
            read_result_reg <= read_result_next;
        end
    end

endmodule

>>> rtl/owm_outreg.sv
// result register between the sequencer and the master-side stream
// depends on owm_pkg

module owm_outreg
    import owm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  tick_out_t load_data,
    input  logic      take,
    output logic      can_load,
    output logic      valid,
    output tick_out_t data
);

    logic      valid_reg, valid_next;
    tick_out_t data_reg;

    assign can_load   = !valid_reg || take;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule
